>>> rtl/brfo_pkg.sv
// Shared types, constants and helpers of the byte ring FIFO.
`default_nettype none
package brfo_pkg;

  localparam int unsigned DEPTH = 256;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = PTR_W + 1;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 9;

  typedef enum logic [1:0] {
    KIND_PUSH,
    KIND_POP,
    KIND_CLEAR
  } kind_e;

  typedef enum logic [1:0] {
    OVF_NONE,
    OVF_SOFT,
    OVF_HARD
  } ovf_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAPACITY,
    CFG_OVERWRITE
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;     // capture the incoming transaction
    logic exec;     // apply the captured transaction to the ring
    logic respond;  // result registers are on the ports
  } cmd_t;

  // Step a ring pointer, wrapping at the effective capacity.
  function automatic logic [PTR_W-1:0] ptr_adv(input logic [PTR_W-1:0] ptr,
                                               input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] nxt;
    nxt = {1'b0, ptr} + CNT_W'(1);
    return (nxt >= cap) ? '0 : nxt[PTR_W-1:0];
  endfunction

endpackage
`default_nettype wire

>>> rtl/brfo_ctrl.sv
// Sequencer of the byte ring FIFO: capture, execute, respond.
`default_nettype none
module brfo_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  output brfo_pkg::cmd_t     cmd_o
);
  import brfo_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign accept = start && !busy;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_EXEC;
      ST_EXEC: state_d = ST_RESP;
      ST_RESP: state_d = accept ? ST_EXEC : ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    busy         = (state_q == ST_EXEC);
    cmd_o.load    = accept;
    cmd_o.exec    = (state_q == ST_EXEC);
    cmd_o.respond = (state_q == ST_RESP);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

>>> rtl/brfo_dpath.sv
// Ring store, pointers, counters and configuration of the byte ring FIFO.
`default_nettype none
module brfo_dpath (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire brfo_pkg::cmd_t                     cmd_i,
  input  wire logic [1:0]                         kind_i,
  input  wire logic [7:0]                         push_byte_i,
  input  wire logic                               cfg_we_i,
  input  wire logic [brfo_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [brfo_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output logic [7:0]                              pop_byte_o,
  output logic                                    pop_valid_o,
  output logic [1:0]                              overflow_status_o,
  output logic [brfo_pkg::CNT_W-1:0]              fill_count_o,
  output logic [brfo_pkg::CNT_W-1:0]              high_water_o
);
  import brfo_pkg::*;

  logic [7:0]       mem_q [DEPTH];
  logic [7:0]       rd_q;

  logic [1:0]       kind_q;
  logic [7:0]       byte_q;
  logic [CNT_W-1:0] cap_q;
  logic             ovw_q;

  logic [PTR_W-1:0] head_q, head_d;
  logic [PTR_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0] held_q, held_d;
  logic [CNT_W-1:0] peak_q, peak_d;
  logic             pv_q, pv_d;
  ovf_e             ovf_q, ovf_d;
  logic             wr_en;
  logic [CNT_W-1:0] cap_eff;

  // Clamp capacity into 1..DEPTH.
  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CNT_W'(1);
    end else if (cap_q > CNT_W'(DEPTH)) begin
      cap_eff = CNT_W'(DEPTH);
    end else begin
      cap_eff = cap_q;
    end
  end

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    held_d = held_q;
    peak_d = peak_q;
    pv_d   = 1'b0;
    ovf_d  = OVF_NONE;
    wr_en  = 1'b0;
    unique case (kind_e'(kind_q))
      KIND_PUSH: begin
        if (held_q >= cap_eff) begin
          if (ovw_q) begin
            head_d = ptr_adv(head_q, cap_eff);
            tail_d = ptr_adv(tail_q, cap_eff);
            wr_en  = 1'b1;
            ovf_d  = OVF_SOFT;
          end else begin
            held_d = cap_eff;
            ovf_d  = OVF_HARD;
          end
        end else begin
          held_d = held_q + CNT_W'(1);
          tail_d = ptr_adv(tail_q, cap_eff);
          wr_en  = 1'b1;
        end
        if (held_d > peak_q) peak_d = held_d;
      end
      KIND_POP: begin
        if (held_q != '0) begin
          pv_d   = 1'b1;
          head_d = ptr_adv(head_q, cap_eff);
          held_d = held_q - CNT_W'(1);
        end
      end
      KIND_CLEAR: begin
        held_d = '0;
        head_d = '0;
        tail_d = '0;
      end
      default: ;
    endcase
  end

  // Ring store: one write port, one registered read port at the head.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wr_en) begin
      mem_q[tail_q] <= byte_q;
    end
    rd_q <= mem_q[head_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_i;
      byte_q <= push_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= CNT_W'(DEPTH);
      ovw_q  <= 1'b0;
      head_q <= '0;
      tail_q <= '0;
      held_q <= '0;
      peak_q <= '0;
      pv_q   <= 1'b0;
      ovf_q  <= OVF_NONE;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_CAPACITY) cap_q <= CNT_W'(cfg_data_i);
        if (cfg_idx_i == CFG_OVERWRITE) ovw_q <= cfg_data_i[0];
      end
      if (cmd_i.exec) begin
        head_q <= head_d;
        tail_q <= tail_d;
        held_q <= held_d;
        peak_q <= peak_d;
        pv_q   <= pv_d;
        ovf_q  <= ovf_d;
      end
    end
  end

  assign pop_byte_o        = pv_q ? rd_q : 8'h00;
  assign pop_valid_o       = pv_q;
  assign overflow_status_o = ovf_q;
  assign fill_count_o      = held_q;
  assign high_water_o      = peak_q;

endmodule
`default_nettype wire

>>> rtl/byte_ring_fifo_overwrite.sv
// Top level of the byte ring FIFO with overwrite-oldest mode.
//
// Command channel: a transaction (kind, push_byte) is taken at a rising edge
// where start is high and busy is low. Kind is push, pop or clear; an unused
// kind changes nothing and still gives a result.
// Result channel: every transaction gives one result, held on the result
// ports for one cycle while result_valid_o is high. The receiver cannot stall.
// The accepting edge moves the sequencer to the execute state, then to the
// respond state, in which the result is on the ports and is taken at the
// rising edge that ends it. The execute state applies the transaction to the
// ring (store write, pointers, counters) and issues the registered store
// read; the respond state presents the result. busy is high only in the
// execute cycle, so a new transaction may be taken while a result is shown.
// Configuration: cfg_valid_i/cfg_ready_o write capacity (index 0) and
// overwrite mode (index 1); ready is always high. Write only while idle.
// Reset: pointers, fill count and high-water mark clear, capacity goes to 256,
// overwrite mode off. The ring store is not cleared; after a capacity change a
// pop can read an entry that was never written.
`default_nettype none
module byte_ring_fifo_overwrite (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [1:0]                         kind_i,
  input  wire logic [7:0]                         push_byte_i,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [brfo_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [brfo_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output logic                                    result_valid_o,
  output logic [7:0]                              pop_byte_o,
  output logic                                    pop_valid_o,
  output logic [1:0]                              overflow_status_o,
  output logic [brfo_pkg::CNT_W-1:0]              fill_count_o,
  output logic [brfo_pkg::CNT_W-1:0]              high_water_o
);
  import brfo_pkg::*;

  cmd_t cmd;

  // Configuration is always taken.
  assign cfg_ready_o = 1'b1;

  brfo_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  brfo_dpath u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .kind_i            (kind_i),
    .push_byte_i       (push_byte_i),
    .cfg_we_i          (cfg_valid_i && cfg_ready_o),
    .cfg_idx_i         (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .pop_byte_o        (pop_byte_o),
    .pop_valid_o       (pop_valid_o),
    .overflow_status_o (overflow_status_o),
    .fill_count_o      (fill_count_o),
    .high_water_o      (high_water_o)
  );

  // Strobe the result while its registers are on the ports.
  assign result_valid_o = cmd.respond;

endmodule
`default_nettype wire

>>> rtl/brfo_checker.sv
// Port-level checks of the byte ring FIFO and their binding.
`default_nettype none
module brfo_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            start,
  input wire logic                            busy,
  input wire logic                            result_valid_o,
  input wire logic [7:0]                      pop_byte_o,
  input wire logic                            pop_valid_o,
  input wire logic [1:0]                      overflow_status_o,
  input wire logic [brfo_pkg::CNT_W-1:0]      fill_count_o,
  input wire logic [brfo_pkg::CNT_W-1:0]      high_water_o
);
  import brfo_pkg::*;

  // Every accepted transaction yields its result strobe.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 result_valid_o)
    else $error("result missing two cycles after transaction");

  // Fill count never passes the high-water mark.
  a_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (fill_count_o <= high_water_o))
    else $error("fill count above high-water mark");

  // A failed or non-pop result carries a zero byte.
  a_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !pop_valid_o) |-> (pop_byte_o == 8'h00))
    else $error("nonzero byte without pop");

  // An overflow belongs to a push, never to a pop.
  a_ovf_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (overflow_status_o != OVF_NONE)) |-> !pop_valid_o)
    else $error("overflow reported on a pop");

  // Results are single-cycle strobes.
  a_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held two cycles");

endmodule

bind byte_ring_fifo_overwrite brfo_checker u_brfo_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .start             (start),
  .busy              (busy),
  .result_valid_o    (result_valid_o),
  .pop_byte_o        (pop_byte_o),
  .pop_valid_o       (pop_valid_o),
  .overflow_status_o (overflow_status_o),
  .fill_count_o      (fill_count_o),
  .high_water_o      (high_water_o)
);
`default_nettype wire

>>> verif/tb_top.sv
// Testbench for the byte ring FIFO: directed table, then random traffic against a predictor.
`timescale 1ns / 100ps
module tb_top;
  import brfo_pkg::*;

  // Kind 3 is not a real operation; the block must answer it and change nothing.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam int unsigned RAND_ITEMS   = 1725;  // random transactions after the table
  localparam int unsigned QUIET_TAIL   = 200;   // last transactions run with no idling
  localparam int unsigned STALL_LIMIT  = 200;   // cycles with no activity on any channel
  localparam int unsigned SETTLE_CYCLES = 3;    // extra wait after the owed results drain

  // One result of the block, field by field.
  typedef struct packed {
    logic [7:0]       pop_byte;
    logic             pop_valid;
    logic [1:0]       ovf;
    logic [CNT_W-1:0] fill;
    logic [CNT_W-1:0] high_water;
  } fifo_result_t;

  // One row of the directed part: either a register write or a command transaction.
  // Rows with typed set carry a hand-written result; the rest use the predictor.
  typedef struct {
    bit                    is_cfg;
    cfg_idx_e              cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_val;
    logic [1:0]            kind;
    logic [7:0]            data;
    bit                    typed;
    fifo_result_t          res;
  } stim_row_t;

  // Clock, reset and block ports; every input is known from time zero.
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  start       = 1'b0;
  logic                  busy;
  logic [1:0]            kind_i      = KIND_PUSH;
  logic [7:0]            push_byte_i = 8'h00;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = CFG_CAPACITY;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  result_valid_o;
  logic [7:0]            pop_byte_o;
  logic                  pop_valid_o;
  logic [1:0]            overflow_status_o;
  logic [CNT_W-1:0]      fill_count_o;
  logic [CNT_W-1:0]      high_water_o;

  // Predictor state: ring contents, which entries were ever written, pointers, counters,
  // and the shadow copy of the two registers.
  logic [7:0]            ring_mem [DEPTH];
  bit                    ring_wr  [DEPTH];
  int unsigned           rd_ptr;
  int unsigned           wr_ptr;
  int unsigned           held;
  int unsigned           peak;
  logic [CFG_DATA_W-1:0] cap_reg;
  logic                  ovw_reg;

  // Results still owed by the block, oldest first.
  fifo_result_t          pending_q [$];
  stim_row_t             stim_rows [$];

  int unsigned errors = 0;
  int unsigned n_push = 0, n_pop = 0, n_clear = 0, n_unused = 0;
  int unsigned n_hit = 0, n_soft = 0, n_hard = 0, n_cfg = 0, n_results = 0;
  int unsigned max_peak = 0;

  byte_ring_fifo_overwrite dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .kind_i            (kind_i),
    .push_byte_i       (push_byte_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .result_valid_o    (result_valid_o),
    .pop_byte_o        (pop_byte_o),
    .pop_valid_o       (pop_valid_o),
    .overflow_status_o (overflow_status_o),
    .fill_count_o      (fill_count_o),
    .high_water_o      (high_water_o)
  );

  // 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Clamp the capacity register: zero behaves as one, anything past the ring as the ring.
  function automatic int unsigned eff_capacity();
    int unsigned c;
    c = cap_reg;
    if (c == 0) c = 1;
    if (c > DEPTH) c = DEPTH;
    return c;
  endfunction

  // Advance a pointer, wrapping once it reaches or passes the capacity.
  function automatic int unsigned ring_next(input int unsigned p, input int unsigned c);
    int unsigned n;
    n = p + 1;
    if (n >= c) n = 0;
    return n;
  endfunction

  // Apply one transaction to the shadow FIFO and return the result it should produce.
  function automatic fifo_result_t fifo_apply(input logic [1:0] kind, input logic [7:0] data);
    fifo_result_t r;
    int unsigned  c;
    r = '0;
    c = eff_capacity();
    case (kind)
      KIND_PUSH: begin
        if (held >= c) begin
          if (ovw_reg) begin
            // Full in overwrite mode: drop the oldest byte, store the new one.
            rd_ptr = ring_next(rd_ptr, c);
            ring_mem[wr_ptr] = data;
            ring_wr[wr_ptr] = 1'b1;
            wr_ptr = ring_next(wr_ptr, c);
            r.ovf = OVF_SOFT;
          end else begin
            // Full otherwise: drop the new byte and pin the count at the capacity.
            held = c;
            r.ovf = OVF_HARD;
          end
        end else begin
          held++;
          ring_mem[wr_ptr] = data;
          ring_wr[wr_ptr] = 1'b1;
          wr_ptr = ring_next(wr_ptr, c);
        end
        if (held > peak) peak = held;
      end
      KIND_POP: begin
        if (held > 0) begin
          r.pop_byte = ring_mem[rd_ptr];
          r.pop_valid = 1'b1;
          rd_ptr = ring_next(rd_ptr, c);
          held--;
        end
      end
      KIND_CLEAR: begin
        // Clear keeps the high-water mark.
        held = 0;
        rd_ptr = 0;
        wr_ptr = 0;
      end
      default: ;
    endcase
    r.fill = CNT_W'(held);
    r.high_water = CNT_W'(peak);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers: inputs change on the falling edge, handshakes are sampled on the rising edge
  // ---------------------------------------------------------------------------

  // Present one command transaction and hold it until the block takes it.
  task automatic send_item(input logic [1:0] kind, input logic [7:0] data,
                           input bit typed, input fifo_result_t typed_res);
    fifo_result_t r;
    @(negedge clk_i);
    start = 1'b1;
    kind_i = kind;
    push_byte_i = data;
    do @(posedge clk_i); while (busy);
    r = fifo_apply(kind, data);
    pending_q.push_back(typed ? typed_res : r);
    case (kind)
      KIND_PUSH:  n_push++;
      KIND_POP:   n_pop++;
      KIND_CLEAR: n_clear++;
      default:    n_unused++;
    endcase
    if (r.pop_valid) n_hit++;
    if (r.ovf == OVF_SOFT) n_soft++;
    if (r.ovf == OVF_HARD) n_hard++;
    if (peak > max_peak) max_peak = peak;
  endtask

  // Drop start for a burst of idle cycles.
  task automatic idle_cycles(input int unsigned n);
    @(negedge clk_i);
    start = 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Drop start, wait for every owed result, then let the pipeline settle.
  task automatic wait_idle(input int unsigned settle);
    @(negedge clk_i);
    start = 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // Write one register through the configuration channel; mirror it in the predictor.
  task automatic cfg_write(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_CAPACITY) cap_reg = val;
    else if (idx == CFG_OVERWRITE) ovw_reg = val[0];
    n_cfg++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Table builders for the directed part.
  task automatic add_cfg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    stim_row_t row;
    row = '{is_cfg: 1'b1, cfg_idx: idx, cfg_val: val, kind: KIND_PUSH, data: 8'h00,
            typed: 1'b0, res: '0};
    stim_rows.push_back(row);
  endtask

  task automatic add_cmd(input logic [1:0] kind, input logic [7:0] data);
    stim_row_t row;
    row = '{is_cfg: 1'b0, cfg_idx: CFG_CAPACITY, cfg_val: '0, kind: kind, data: data,
            typed: 1'b0, res: '0};
    stim_rows.push_back(row);
  endtask

  task automatic add_chk(input logic [1:0] kind, input logic [7:0] data,
                         input logic [7:0] pb, input logic pv, input ovf_e ovf,
                         input logic [CNT_W-1:0] fc, input logic [CNT_W-1:0] hw);
    stim_row_t row;
    row = '{is_cfg: 1'b0, cfg_idx: CFG_CAPACITY, cfg_val: '0, kind: kind, data: data,
            typed: 1'b1, res: '{pb, pv, ovf, fc, hw}};
    stim_rows.push_back(row);
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  function automatic void check_field(input string name, input logic [8:0] want,
                                      input logic [8:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // Take each strobed result and compare it with the oldest owed result.
  always @(posedge clk_i) begin
    fifo_result_t want;
    if (rst_ni && result_valid_o) begin
      n_results++;
      if (pending_q.size() == 0) begin
        $error("result strobed with no transaction outstanding");
        errors++;
      end else begin
        want = pending_q.pop_front();
        check_field("pop_byte", 9'(want.pop_byte), 9'(pop_byte_o));
        check_field("pop_valid", 9'(want.pop_valid), 9'(pop_valid_o));
        check_field("overflow_status", 9'(want.ovf), 9'(overflow_status_o));
        check_field("fill_count", 9'(want.fill), 9'(fill_count_o));
        check_field("high_water", 9'(want.high_water), 9'(high_water_o));
      end
    end
  end

  // Watchdog: end the run if nothing moves on any channel for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin
    stim_row_t             row;
    int unsigned           rand_done;
    int unsigned           phase;
    int unsigned           phase_len;
    int unsigned           burst_left;
    int unsigned           mode;
    int unsigned           roll;
    bit                    idle_on;
    logic [1:0]            kind;
    logic [CFG_DATA_W-1:0] cap_val;

    // Predictor starts from the reset state.
    foreach (ring_wr[i]) ring_wr[i] = 1'b0;
    foreach (ring_mem[i]) ring_mem[i] = 8'h00;
    rd_ptr = 0;
    wr_ptr = 0;
    held = 0;
    peak = 0;
    cap_reg = 9'd256;
    ovw_reg = 1'b0;

    // Directed table. Defaults after reset: capacity 256, overwrite off.
    add_chk(KIND_POP,    8'h00, 8'h00, 1'b0, OVF_NONE, 9'd0, 9'd0);  // pop when empty
    add_chk(KIND_UNUSED, 8'hFF, 8'h00, 1'b0, OVF_NONE, 9'd0, 9'd0);  // unused kind
    add_chk(KIND_CLEAR,  8'h00, 8'h00, 1'b0, OVF_NONE, 9'd0, 9'd0);
    add_chk(KIND_PUSH,   8'h00, 8'h00, 1'b0, OVF_NONE, 9'd1, 9'd1);
    add_chk(KIND_PUSH,   8'hFF, 8'h00, 1'b0, OVF_NONE, 9'd2, 9'd2);
    add_chk(KIND_POP,    8'h00, 8'h00, 1'b1, OVF_NONE, 9'd1, 9'd2);
    add_chk(KIND_POP,    8'h00, 8'hFF, 1'b1, OVF_NONE, 9'd0, 9'd2);
    // Capacity zero acts as one entry: second push is a hard overflow.
    add_cfg(CFG_CAPACITY, 9'd0);
    add_chk(KIND_PUSH,   8'hA5, 8'h00, 1'b0, OVF_NONE, 9'd1, 9'd2);
    add_chk(KIND_PUSH,   8'h5A, 8'h00, 1'b0, OVF_HARD, 9'd1, 9'd2);
    add_cfg(CFG_OVERWRITE, 9'd1);
    add_chk(KIND_PUSH,   8'h3C, 8'h00, 1'b0, OVF_SOFT, 9'd1, 9'd2);
    add_cmd(KIND_POP,    8'h00);
    // Capacity past the ring acts as the full ring.
    add_cfg(CFG_CAPACITY, 9'd511);
    add_cfg(CFG_OVERWRITE, 9'd0);
    add_cmd(KIND_CLEAR,  8'h00);
    add_cfg(CFG_CAPACITY, 9'd2);
    add_cmd(KIND_PUSH,   8'h11);
    add_cmd(KIND_PUSH,   8'h22);
    add_chk(KIND_PUSH,   8'h33, 8'h00, 1'b0, OVF_HARD, 9'd2, 9'd2);
    add_cfg(CFG_OVERWRITE, 9'd1);
    add_chk(KIND_PUSH,   8'h44, 8'h00, 1'b0, OVF_SOFT, 9'd2, 9'd2);
    add_cmd(KIND_POP,    8'h00);
    add_cmd(KIND_POP,    8'h00);
    add_chk(KIND_POP,    8'h00, 8'h00, 1'b0, OVF_NONE, 9'd0, 9'd2);
    // Shrink the capacity while bytes are held: count above capacity means full.
    add_cfg(CFG_CAPACITY, 9'd256);
    add_cmd(KIND_PUSH,   8'h80);
    add_cmd(KIND_PUSH,   8'h01);
    add_cfg(CFG_CAPACITY, 9'd1);
    add_cmd(KIND_PUSH,   8'h7E);
    add_cmd(KIND_POP,    8'h00);
    add_cmd(KIND_POP,    8'h00);
    add_cmd(KIND_CLEAR,  8'h00);

    // Hold reset, then release it on a falling edge.
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Walk the table; registers change only once the block has drained.
    foreach (stim_rows[i]) begin
      row = stim_rows[i];
      if (row.is_cfg) begin
        wait_idle(SETTLE_CYCLES);
        cfg_write(row.cfg_idx, row.cfg_val);
      end else begin
        send_item(row.kind, row.data, row.typed, row.res);
      end
    end

    // Random phases, each under its own register setting. Phases do not always
    // clear first, so capacity changes also land on a partly filled ring.
    rand_done = 0;
    phase = 0;
    burst_left = 0;
    mode = 0;
    while (rand_done < RAND_ITEMS) begin
      wait_idle(SETTLE_CYCLES);
      case (phase)
        0: cap_val = 9'd256;
        1: cap_val = 9'd1;
        2: cap_val = 9'd0;
        3: cap_val = 9'd511;
        default: begin
          case ($urandom_range(0, 9))
            0:       cap_val = 9'd0;
            1:       cap_val = 9'd1;
            2:       cap_val = 9'd256;
            3:       cap_val = CFG_DATA_W'($urandom_range(257, 511));
            4, 5, 6, 7: cap_val = CFG_DATA_W'($urandom_range(2, 8));
            8:       cap_val = CFG_DATA_W'($urandom_range(9, 40));
            default: cap_val = CFG_DATA_W'($urandom_range(1, 256));
          endcase
        end
      endcase
      cfg_write(CFG_CAPACITY, cap_val);
      if (phase == 0) cfg_write(CFG_OVERWRITE, 9'd0);
      else if (phase == 1) cfg_write(CFG_OVERWRITE, 9'd1);
      else cfg_write(CFG_OVERWRITE, CFG_DATA_W'($urandom_range(0, 1)));

      if (phase != 0 && $urandom_range(0, 1) == 0) begin
        send_item(KIND_CLEAR, 8'($urandom_range(0, 255)), 1'b0, '0);
        rand_done++;
      end

      phase_len = $urandom_range(60, 180);
      if (phase == 0) begin
        // Fill the whole ring and beyond: reach the top count and hard overflow.
        phase_len = 400;
        mode = 3;
        burst_left = 270;
      end
      idle_on = (phase % 3) != 2;  // every third phase runs back to back

      for (int unsigned i = 0; i < phase_len && rand_done < RAND_ITEMS; i++) begin
        if (burst_left == 0) begin
          mode = $urandom_range(0, 2);
          burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        roll = $urandom_range(0, 99);
        case (mode)
          0: kind = (roll < 80) ? KIND_PUSH : (roll < 96) ? KIND_POP :
                    (roll < 98) ? KIND_CLEAR : KIND_UNUSED;
          1: kind = (roll < 15) ? KIND_PUSH : (roll < 95) ? KIND_POP :
                    (roll < 97) ? KIND_CLEAR : KIND_UNUSED;
          2: kind = (roll < 47) ? KIND_PUSH : (roll < 94) ? KIND_POP :
                    (roll < 97) ? KIND_CLEAR : KIND_UNUSED;
          default: kind = KIND_PUSH;
        endcase
        // Never pop an entry that was never written; push instead.
        if (kind == KIND_POP && held > 0 && !ring_wr[rd_ptr]) kind = KIND_PUSH;
        send_item(kind, 8'($urandom_range(0, 255)), 1'b0, '0);
        rand_done++;
        if (idle_on && rand_done < RAND_ITEMS - QUIET_TAIL && $urandom_range(0, 3) == 0)
          idle_cycles($urandom_range(1, 7));
      end
      phase++;
    end

    // Drain: every owed result, then a further settle wait for stray strobes.
    wait_idle(SETTLE_CYCLES + 5);

    $display("%0d items in %0d phases: %0d push, %0d pop (%0d hit), %0d clear, %0d unused kind",
             n_push + n_pop + n_clear + n_unused, phase, n_push, n_pop, n_hit, n_clear,
             n_unused);
    $display("%0d soft and %0d hard overflows, peak fill %0d, %0d config writes, %0d results",
             n_soft, n_hard, max_peak, n_cfg, n_results);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/brfo_pkg.sv
rtl/brfo_ctrl.sv
rtl/brfo_dpath.sv
rtl/byte_ring_fifo_overwrite.sv
rtl/brfo_checker.sv
verif/tb_top.sv
